[hw/rtl/cnms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS shared definitions
// Constants, codes and types used across the non-maximum suppression block.
// ----------------------------------------------------------------------------
package cnms_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAG_BITS        = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 13;

  // Fixed field widths.
  localparam int ANGLE_W    = 16;
  localparam int FIELD_W    = 11;
  localparam int ROW_W      = 11;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Frame size limits and reset values.
  localparam int               MIN_DIM      = 3;
  localparam int               HEIGHT_CAP   = 1024;
  localparam logic [FIELD_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [FIELD_W-1:0] HEIGHT_RESET = 11'd480;

  // Depth of the result queue; a power of two.
  localparam int RES_Q_DEPTH = 4;

  // Angle thresholds in Q2.30: pi, pi/8, 3pi/8, 5pi/8, 7pi/8.
  localparam longint unsigned Q30_PI  = 64'd3373259426;
  localparam longint unsigned Q30_22  = 64'd421657428;
  localparam longint unsigned Q30_67  = 64'd1264972285;
  localparam longint unsigned Q30_112 = 64'd2108287141;
  localparam longint unsigned Q30_157 = 64'd2951601998;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Gradient direction sectors.
  typedef enum logic [1:0] {
    SEC_VERT = 2'd0,
    SEC_DIAG = 2'd1,
    SEC_HORZ = 2'd2,
    SEC_ANTI = 2'd3
  } sector_t;

  // Control of the item in the line buffer read stage.
  typedef struct packed {
    logic valid;
    logic emit;
    logic rows_ok;
    logic cols_ok;
    logic last;
    logic fwd;
  } stage_ctrl_t;

  // Rounds a Q2.30 constant to nearest at the given number of fraction bits.
  function automatic int q30_to_angle(input longint unsigned k, input int fb);
    longint unsigned r;
    r = (k + (64'd1 << (29 - fb))) >> (30 - fb);
    return int'(r);
  endfunction

endpackage

[hw/rtl/cnms_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS pixel channel
// Valid/ready channel carrying one gradient pixel word.
// ----------------------------------------------------------------------------
interface cnms_pix_if #(
  parameter int MAG_BITS = cnms_pkg::DEF_MAG_BITS
) ();
  logic                               valid;
  logic                               ready;
  logic [MAG_BITS-1:0]                magnitude;
  logic signed [cnms_pkg::ANGLE_W-1:0] angle;
  logic                               pad;
  logic                               frame_start;

  modport source (output valid, magnitude, angle, pad, frame_start, input ready);
  modport sink   (input valid, magnitude, angle, pad, frame_start, output ready);
endinterface

[hw/rtl/cnms_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS result channel
// Valid/ready channel carrying one suppressed magnitude word.
// ----------------------------------------------------------------------------
interface cnms_res_if #(
  parameter int MAG_BITS = cnms_pkg::DEF_MAG_BITS
) ();
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] suppressed_magnitude;
  logic                frame_last;

  modport source (output valid, suppressed_magnitude, frame_last, input ready);
  modport sink   (input valid, suppressed_magnitude, frame_last, output ready);
endinterface

[hw/rtl/cnms_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS generic RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cnms_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/cnms_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS configuration registers
// APB-style frame size registers and the clamped sizes used by the datapath.
// ----------------------------------------------------------------------------
module cnms_cfg #(
  parameter int  MAX_WIDTH = cnms_pkg::DEF_MAX_WIDTH,
  localparam int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cnms_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cnms_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cnms_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [WW-1:0]                       eff_w,
  output logic [cnms_pkg::ROW_W-1:0]          eff_h
);

  logic [cnms_pkg::FIELD_W-1:0] frame_width;
  logic [cnms_pkg::FIELD_W-1:0] frame_height;
  logic                         wr_en;
  cnms_pkg::reg_idx_t           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = cnms_pkg::reg_idx_t'(paddr[cnms_pkg::APB_ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= cnms_pkg::WIDTH_RESET;
      frame_height <= cnms_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        cnms_pkg::REG_WIDTH:  frame_width  <= pwdata[cnms_pkg::FIELD_W-1:0];
        cnms_pkg::REG_HEIGHT: frame_height <= pwdata[cnms_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cnms_pkg::REG_WIDTH:  prdata = cnms_pkg::APB_DATA_W'(frame_width);
      cnms_pkg::REG_HEIGHT: prdata = cnms_pkg::APB_DATA_W'(frame_height);
      default:              prdata = '0;
    endcase
  end

  // Sizes outside the supported range are clamped.
  always_comb begin
    if (frame_width < cnms_pkg::FIELD_W'(cnms_pkg::MIN_DIM)) begin
      eff_w = WW'(cnms_pkg::MIN_DIM);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end

    if (frame_height < cnms_pkg::FIELD_W'(cnms_pkg::MIN_DIM)) begin
      eff_h = cnms_pkg::ROW_W'(cnms_pkg::MIN_DIM);
    end else if (32'(frame_height) > 32'(cnms_pkg::HEIGHT_CAP)) begin
      eff_h = cnms_pkg::ROW_W'(cnms_pkg::HEIGHT_CAP);
    end else begin
      eff_h = cnms_pkg::ROW_W'(frame_height);
    end
  end

endmodule

[hw/rtl/cnms_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS input sequencer
// Raster counters, sector sorting, line buffer read and the read stage register.
// ----------------------------------------------------------------------------
module cnms_seq #(
  parameter int  MAX_WIDTH       = cnms_pkg::DEF_MAX_WIDTH,
  parameter int  MAG_BITS        = cnms_pkg::DEF_MAG_BITS,
  parameter int  ANGLE_FRAC_BITS = cnms_pkg::DEF_ANGLE_FRAC_BITS,
  localparam int CW              = $clog2(MAX_WIDTH),
  localparam int WW              = $clog2(MAX_WIDTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  cnms_pix_if.sink                     pixel,
  input  logic                         space,
  input  logic [WW-1:0]                eff_w,
  input  logic [cnms_pkg::ROW_W-1:0]   eff_h,
  output logic                         rd_en,
  output logic [CW-1:0]                rd_addr,
  output cnms_pkg::stage_ctrl_t        s1_ctrl,
  output logic [MAG_BITS-1:0]          s1_mag,
  output cnms_pkg::sector_t            s1_sec,
  output logic [CW-1:0]                s1_col
);

  localparam int ANG_PI  = cnms_pkg::q30_to_angle(cnms_pkg::Q30_PI, ANGLE_FRAC_BITS);
  localparam int ANG_22  = cnms_pkg::q30_to_angle(cnms_pkg::Q30_22, ANGLE_FRAC_BITS);
  localparam int ANG_67  = cnms_pkg::q30_to_angle(cnms_pkg::Q30_67, ANGLE_FRAC_BITS);
  localparam int ANG_112 = cnms_pkg::q30_to_angle(cnms_pkg::Q30_112, ANGLE_FRAC_BITS);
  localparam int ANG_157 = cnms_pkg::q30_to_angle(cnms_pkg::Q30_157, ANGLE_FRAC_BITS);
  localparam int AW      = $clog2(ANG_PI + (1 << (cnms_pkg::ANGLE_W - 1))) + 1;

  localparam logic signed [AW-1:0] A_PI  = AW'(ANG_PI);
  localparam logic signed [AW-1:0] A_22  = AW'(ANG_22);
  localparam logic signed [AW-1:0] A_67  = AW'(ANG_67);
  localparam logic signed [AW-1:0] A_112 = AW'(ANG_112);
  localparam logic signed [AW-1:0] A_157 = AW'(ANG_157);

  logic [CW-1:0]               in_column;
  logic [cnms_pkg::ROW_W-1:0]  in_row;
  logic [CW-1:0]               col_a;
  logic [cnms_pkg::ROW_W-1:0]  row_a;
  logic [WW-1:0]               col_inc;
  logic                        wrap;
  logic                        ignore;
  logic                        accept;
  logic [CW-1:0]               col_next;
  logic [cnms_pkg::ROW_W-1:0]  row_next;
  logic signed [AW-1:0]        ang_fold;
  cnms_pkg::sector_t           sec_in;
  logic                        k1;
  logic                        k2;
  cnms_pkg::stage_ctrl_t       ctrl_next;

  assign pixel.ready = space;
  assign accept      = pixel.valid && space;

  // Negative directions are folded by half a turn before sorting.
  always_comb begin
    if (pixel.angle[cnms_pkg::ANGLE_W-1]) begin
      ang_fold = AW'(pixel.angle) + A_PI;
    end else begin
      ang_fold = AW'(pixel.angle);
    end
    if (ang_fold <= A_22 || ang_fold > A_157) begin
      sec_in = cnms_pkg::SEC_VERT;
    end else if (ang_fold <= A_67) begin
      sec_in = cnms_pkg::SEC_DIAG;
    end else if (ang_fold <= A_112) begin
      sec_in = cnms_pkg::SEC_HORZ;
    end else begin
      sec_in = cnms_pkg::SEC_ANTI;
    end
  end

  // Position of this word, after a late wrap and a frame restart.
  always_comb begin
    col_a = in_column;
    row_a = in_row;
    if (WW'(in_column) >= eff_w) begin
      col_a = '0;
      row_a = in_row + 1'b1;
    end
    if (pixel.frame_start || (!pixel.pad && row_a >= eff_h)) begin
      col_a = '0;
      row_a = '0;
    end
    // Pads only count on the flush row and at the start of the row after it.
    ignore = pixel.pad &&
             !(row_a == eff_h || (row_a == eff_h + 1'b1 && col_a == '0));

    col_inc = WW'(col_a) + 1'b1;
    wrap    = col_inc >= eff_w;
    if (ignore) begin
      col_next = col_a;
      row_next = row_a;
    end else if (wrap) begin
      col_next = '0;
      row_next = row_a + 1'b1;
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = row_a;
    end

    // A row start judges the last pixel two rows up, any other column the
    // pixel one row up and one column left.
    k2 = col_a == '0 && row_a >= cnms_pkg::ROW_W'(2);
    k1 = col_a != '0 && row_a != '0;

    ctrl_next.valid   = accept && !ignore;
    ctrl_next.emit    = k1 || k2;
    ctrl_next.rows_ok = k2 ? (row_a >= cnms_pkg::ROW_W'(3) && row_a <= eff_h)
                           : (row_a >= cnms_pkg::ROW_W'(2) && row_a < eff_h);
    ctrl_next.cols_ok = k1 && col_a >= CW'(2);
    ctrl_next.last    = k2 && row_a == eff_h + 1'b1;
    ctrl_next.fwd     = s1_ctrl.valid && s1_col == col_a;
  end

  assign rd_en   = ctrl_next.valid;
  assign rd_addr = col_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      s1_ctrl   <= '0;
    end else begin
      s1_ctrl <= ctrl_next;
      if (accept) begin
        in_column <= col_next;
        in_row    <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_mag <= pixel.pad ? '0 : pixel.magnitude;
      s1_sec <= pixel.pad ? cnms_pkg::SEC_VERT : sec_in;
      s1_col <= col_a;
    end
  end

endmodule

[hw/rtl/cnms_judge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS window and compare
// Line buffer write-back with forwarding, the window columns and the compare.
// ----------------------------------------------------------------------------
module cnms_judge #(
  parameter int  MAX_WIDTH = cnms_pkg::DEF_MAX_WIDTH,
  parameter int  MAG_BITS  = cnms_pkg::DEF_MAG_BITS,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int DW        = 2 * MAG_BITS + 2
) (
  input  logic                   clk,
  input  cnms_pkg::stage_ctrl_t  s1_ctrl,
  input  logic [MAG_BITS-1:0]    s1_mag,
  input  cnms_pkg::sector_t      s1_sec,
  input  logic [CW-1:0]          s1_col,
  input  logic [DW-1:0]          rd_data,
  output logic                   wr_en,
  output logic [CW-1:0]          wr_addr,
  output logic [DW-1:0]          wr_data,
  output logic                   push,
  output logic [MAG_BITS-1:0]    push_mag,
  output logic                   push_last
);

  // Window columns: *1 is one column left of *2; top, mid, bot are rows.
  logic [MAG_BITS-1:0] top1, top2, mid1, mid2, bot1, bot2;
  cnms_pkg::sector_t   center_sec;
  logic [DW-1:0]       fwd_word;
  logic [DW-1:0]       rd_word;
  logic [MAG_BITS-1:0] top_in;
  logic [MAG_BITS-1:0] mid_in;
  cnms_pkg::sector_t   sec_rd;
  logic [MAG_BITS-1:0] na;
  logic [MAG_BITS-1:0] nb;
  logic                cmp;

  // The word written last cycle has not reached the RAM output yet.
  assign rd_word = s1_ctrl.fwd ? fwd_word : rd_data;
  assign top_in  = rd_word[DW-1 -: MAG_BITS];
  assign mid_in  = rd_word[MAG_BITS+1 -: MAG_BITS];
  assign sec_rd  = cnms_pkg::sector_t'(rd_word[1:0]);

  assign wr_en   = s1_ctrl.valid;
  assign wr_addr = s1_col;
  assign wr_data = {mid_in, s1_mag, s1_sec};

  always_comb begin
    na  = top2;
    nb  = bot2;
    cmp = 1'b0;
    case (center_sec)
      cnms_pkg::SEC_VERT: begin
        na  = top2;
        nb  = bot2;
        cmp = s1_ctrl.rows_ok;
      end
      cnms_pkg::SEC_DIAG: begin
        na  = top1;
        nb  = s1_mag;
        cmp = s1_ctrl.rows_ok && s1_ctrl.cols_ok;
      end
      cnms_pkg::SEC_HORZ: begin
        na  = mid1;
        nb  = mid_in;
        cmp = s1_ctrl.cols_ok;
      end
      cnms_pkg::SEC_ANTI: begin
        na  = bot1;
        nb  = top_in;
        cmp = s1_ctrl.rows_ok && s1_ctrl.cols_ok;
      end
    endcase
  end

  assign push      = s1_ctrl.valid && s1_ctrl.emit;
  assign push_mag  = (cmp && (na > mid2 || nb > mid2)) ? '0 : mid2;
  assign push_last = s1_ctrl.last;

  always_ff @(posedge clk) begin
    if (s1_ctrl.valid) begin
      top1       <= top2;
      top2       <= top_in;
      mid1       <= mid2;
      mid2       <= mid_in;
      bot1       <= bot2;
      bot2       <= s1_mag;
      center_sec <= sec_rd;
      fwd_word   <= wr_data;
    end
  end

endmodule

[hw/rtl/cnms_res_q.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS result queue
// Small register queue that decouples the result channel from the pipeline.
// ----------------------------------------------------------------------------
module cnms_res_q #(
  parameter int MAG_BITS = cnms_pkg::DEF_MAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [MAG_BITS-1:0] push_mag,
  input  logic                push_last,
  output logic                space,
  cnms_res_if.source          result
);

  localparam int DEPTH = cnms_pkg::RES_Q_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  logic [MAG_BITS-1:0] q_mag  [DEPTH];
  logic                q_last [DEPTH];
  logic [PW-1:0]       wptr;
  logic [PW-1:0]       rptr;
  logic [PW:0]         count;
  logic                pop;

  assign pop                         = result.valid && result.ready;
  assign result.valid                = count != '0;
  assign result.suppressed_magnitude = q_mag[rptr];
  assign result.frame_last           = q_last[rptr];

  // A word accepted now lands after the read stage register; the word being
  // pushed now is counted so that it always has a slot.
  assign space = (count + (PW+1)'(push)) < (PW+1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mag[wptr]  <= push_mag;
      q_last[wptr] <= push_last;
    end
  end

endmodule

[hw/rtl/canny_non_max_suppression.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny non-maximum suppression
// Streaming 3x3 non-maximum suppression over gradient magnitude and angle.
// ----------------------------------------------------------------------------
// The block takes one gradient pixel word per clock in raster order and
// returns the suppressed magnitude of the pixel one row and one column
// behind it, so a frame's last W+1 results are pushed out by pad words sent
// after its last pixel. The sustained rate is one word per cycle; the input
// stalls only when the four-word result queue is full because the result
// side is not taking words. A result passes the read stage register and the
// queue before it leaves the block. Both previous rows live in a single
// line-buffer RAM of MAX_WIDTH words, each holding the row above, the center
// row and the center sector of one column. The RAM is read when a word is
// accepted and written back next cycle; back-to-back words that land on
// the same column (a frame restart at column zero) take the just-written
// word from a forwarding register. The RAM is never cleared: its unwritten
// entries are read only for neighbors outside the frame, which are never
// compared. Direction sectors split at 22.5, 67.5, 112.5 and 157.5 degrees
// after negative angles are folded by pi; a pixel is zeroed when either
// neighbor along its sector is strictly larger, and pixels whose neighbors
// fall outside the frame keep their magnitude. Frame width (register 0,
// byte address 0) and height (register 1, byte address 4) are clamped to
// 3..MAX_WIDTH and 3..1024 and should be written only while the block is
// idle.
// ----------------------------------------------------------------------------
module canny_non_max_suppression #(
  parameter int MAX_WIDTH       = cnms_pkg::DEF_MAX_WIDTH,
  parameter int MAG_BITS        = cnms_pkg::DEF_MAG_BITS,
  parameter int ANGLE_FRAC_BITS = cnms_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  cnms_pix_if.sink                        pixel,
  cnms_res_if.source                      result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cnms_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cnms_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cnms_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int DW = 2 * MAG_BITS + 2;

  // Clamped frame size.
  logic [WW-1:0]              eff_w;
  logic [cnms_pkg::ROW_W-1:0] eff_h;

  // Line buffer ports.
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // Read stage, registered in the cycle after acceptance.
  cnms_pkg::stage_ctrl_t s1_ctrl;
  logic [MAG_BITS-1:0]   s1_mag;
  cnms_pkg::sector_t     s1_sec;
  logic [CW-1:0]         s1_col;

  // Results into the queue.
  logic                push;
  logic [MAG_BITS-1:0] push_mag;
  logic                push_last;
  logic                space;

  cnms_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff_w   (eff_w),
    .eff_h   (eff_h)
  );

  // Counters, sector sorting and the line buffer read.
  cnms_seq #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAG_BITS        (MAG_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel),
    .space   (space),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .s1_ctrl (s1_ctrl),
    .s1_mag  (s1_mag),
    .s1_sec  (s1_sec),
    .s1_col  (s1_col)
  );

  // Line buffer: {row above, center row, center sector} per column.
  cnms_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Window shift, write-back and the neighbor compare.
  cnms_judge #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAG_BITS  (MAG_BITS)
  ) u_judge (
    .clk       (clk),
    .s1_ctrl   (s1_ctrl),
    .s1_mag    (s1_mag),
    .s1_sec    (s1_sec),
    .s1_col    (s1_col),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_mag  (push_mag),
    .push_last (push_last)
  );

  // Result queue; its free space gates input acceptance.
  cnms_res_q #(
    .MAG_BITS (MAG_BITS)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_mag  (push_mag),
    .push_last (push_last),
    .space     (space),
    .result    (result)
  );

endmodule

[sim/cnms_nms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS stream checker
// Watches the pixel, result and register channels of the block, predicts
// every suppressed magnitude word and compares each result word against it.
// ----------------------------------------------------------------------------
module cnms_nms_checker (
  input  logic                            clk,
  input  logic                            rst,
  cnms_pix_if                             pix,
  cnms_res_if                             res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cnms_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cnms_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [cnms_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              pending
);
  import cnms_pkg::*;

  localparam int MAX_W      = DEF_MAX_WIDTH;
  localparam int MAG_W      = DEF_MAG_BITS;
  localparam int MAX_PRINTS = 100;

  // Pi and the sector edges in Q2.13 radians.
  localparam int ANG_PI  = 25736;
  localparam int ANG_22  = 3217;
  localparam int ANG_67  = 9651;
  localparam int ANG_112 = 16085;
  localparam int ANG_157 = 22519;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             last;
  } nms_word_t;

  nms_word_t           suppressed_q [$];
  nms_word_t           want;
  logic [MAG_W-1:0]    line_above [MAX_W];
  logic [MAG_W-1:0]    line_center [MAX_W];
  sector_t             line_sector [MAX_W];
  logic [MAG_W-1:0]    win [3][3];
  sector_t             center_dir;
  int                  col_cnt;
  int                  row_cnt;
  logic [FIELD_W-1:0]  width_reg;
  logic [FIELD_W-1:0]  height_reg;

  function automatic sector_t direction_of(input logic signed [ANGLE_W-1:0] ang);
    int a;
    a = ang;
    if (a < 0) a = a + ANG_PI;
    if (a <= ANG_22 || a > ANG_157) return SEC_VERT;
    if (a <= ANG_67) return SEC_DIAG;
    if (a <= ANG_112) return SEC_HORZ;
    return SEC_ANTI;
  endfunction

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Judges the middle-row window pixel in column k (1 or 2) at frame (r, c).
  function automatic logic [MAG_W-1:0] judge_pixel(input int k, input int r, input int c,
                                                   input int w, input int h,
                                                   input sector_t dir);
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    bit               rows_ok;
    bit               cols_ok;
    bit               compared;
    m       = win[1][k];
    rows_ok = (r >= 1) && (r + 1 < h);
    cols_ok = (k == 1) && (c >= 1) && (c + 1 < w);
    case (dir)
      SEC_VERT: begin
        compared = rows_ok;
        a = win[0][k];
        b = win[2][k];
      end
      SEC_DIAG: begin
        compared = rows_ok && cols_ok;
        a = win[0][0];
        b = win[2][2];
      end
      SEC_HORZ: begin
        compared = cols_ok;
        a = win[1][0];
        b = win[1][2];
      end
      default: begin
        compared = rows_ok && cols_ok;
        a = win[2][0];
        b = win[0][2];
      end
    endcase
    if (compared && (a > m || b > m)) return '0;
    return m;
  endfunction

  task automatic predict_word(input logic [MAG_W-1:0] mag_in,
                              input logic signed [ANGLE_W-1:0] ang,
                              input logic pad, input logic start);
    int               w;
    int               h;
    int               r;
    int               c;
    int               rr;
    int               cc;
    int               i;
    int               j;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] top;
    logic [MAG_W-1:0] mid;
    logic [MAG_W-1:0] outcome;
    sector_t          dir_in;
    sector_t          dir_read;
    bit               emit;
    w       = clamp_dim(int'(width_reg), MAX_W);
    h       = clamp_dim(int'(height_reg), HEIGHT_CAP);
    emit    = 1'b0;
    outcome = '0;
    rr      = 0;
    cc      = 0;
    // A column counter left past a narrower width wraps first.
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (start || (!pad && row_cnt >= h)) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    // Pads count only while the tail of a frame is being flushed.
    if (pad && !(row_cnt == h || (row_cnt == h + 1 && col_cnt == 0))) return;
    r = row_cnt;
    c = col_cnt;
    if (pad) begin
      mag    = '0;
      dir_in = SEC_VERT;
    end else begin
      mag    = mag_in;
      dir_in = direction_of(ang);
    end
    // The last pixel of the previous row is judged before the window shifts.
    if (c == 0 && r >= 2) begin
      rr      = r - 2;
      cc      = w - 1;
      outcome = judge_pixel(2, rr, cc, w, h, center_dir);
      emit    = 1'b1;
    end
    top            = line_above[c];
    mid            = line_center[c];
    dir_read       = line_sector[c];
    line_above[c]  = mid;
    line_center[c] = mag;
    line_sector[c] = dir_in;
    for (i = 0; i < 2; i++) begin
      for (j = 0; j < 3; j++) win[j][i] = win[j][i+1];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = mag;
    if (c >= 1 && r >= 1) begin
      rr      = r - 1;
      cc      = c - 1;
      outcome = judge_pixel(1, rr, cc, w, h, center_dir);
      emit    = 1'b1;
    end
    center_dir = dir_read;
    col_cnt    = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end
    if (emit) suppressed_q.push_back('{mag: outcome, last: (rr == h - 1 && cc == w - 1)});
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] expv,
                               input logic [31:0] gotv);
    if (fail_count < MAX_PRINTS)
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, expv, gotv);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      suppressed_q.delete();
      for (int i = 0; i < MAX_W; i++) begin
        line_above[i]  = '0;
        line_center[i] = '0;
        line_sector[i] = SEC_VERT;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      center_dir = SEC_VERT;
      col_cnt    = 0;
      row_cnt    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      fail_count = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
            REG_WIDTH:  width_reg  = pwdata[FIELD_W-1:0];
            REG_HEIGHT: height_reg = pwdata[FIELD_W-1:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
            REG_WIDTH:
              if (prdata !== 32'(width_reg)) note_mismatch("width readback", width_reg, prdata);
            REG_HEIGHT:
              if (prdata !== 32'(height_reg))
                note_mismatch("height readback", height_reg, prdata);
            default: ;
          endcase
        end
      end
      if (pix.valid && pix.ready)
        predict_word(pix.magnitude, pix.angle, pix.pad, pix.frame_start);
      if (res.valid && res.ready) begin
        if (suppressed_q.size() == 0) begin
          note_mismatch("result word with none awaited", 32'd0, res.suppressed_magnitude);
        end else begin
          want = suppressed_q.pop_front();
          if (res.suppressed_magnitude !== want.mag)
            note_mismatch("suppressed_magnitude", want.mag, res.suppressed_magnitude);
          if (res.frame_last !== want.last)
            note_mismatch("frame_last", want.last, res.frame_last);
        end
      end
    end
    pending = suppressed_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canny NMS testbench
// Drives frames of gradient pixel words and register writes into the block
// under random idling and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import cnms_pkg::*;

  // The run is stopped here no matter what; the slowest correct run is far
  // below this.
  localparam int CYCLE_LIMIT  = 400000;
  // Length of the long result-side stall that fills the block up.
  localparam int HOLD_CYCLES  = 400;
  // Extra cycles after the last result word, covering pads still in flight.
  localparam int DRAIN_CYCLES = 16;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int PHASE_WORDS  = 650;
  localparam int SET_WORDS    = 110;
  // Frames larger than this are cut short so the run stays short.
  localparam int BIG_FRAME    = 150;

  // Folded angle edges in Q2.13, used to aim random angles at the borders.
  localparam int ANG_PI = 25736;
  localparam int ANGLE_EDGES [5] = '{0, 3217, 9651, 16085, 22519};

  // Register settings tried at the start of each phase, three per phase.
  // They include the all-zero and all-one values and ones that clamp.
  localparam int FIXED_W [9] = '{3, 0, 2047, 3, 6, 1, 12, 3, 5};
  localparam int FIXED_H [9] = '{3, 1, 3, 2047, 5, 2, 3, 1024, 4};

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int src_idle   = 0;
  int snk_idle   = 0;
  int hold_reqs  = 0;
  int cycle_cnt  = 0;
  int words_sent = 0;

  cnms_pix_if pix_ch ();
  cnms_res_if res_ch ();

  canny_non_max_suppression u_dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cnms_nms_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result-side ready. It idles at random at the rate the current phase
  // sets, and on each new hold request it stays low for a long stretch so
  // that the result queue fills and the block stalls its pixel input.
  initial begin
    int hold_left;
    int hold_taken;
    hold_left    = 0;
    hold_taken   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_taken != hold_reqs) begin
        hold_taken   = hold_reqs;
        hold_left    = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
      end
    end
  end

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Magnitudes: full range, small values that make ties likely, and the
  // two extremes.
  function automatic logic [15:0] rand_mag();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($urandom);
    if (sel < 9) return 16'($urandom_range(0, 7));
    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endfunction

  // Angles: mostly the atan2 range, some right on a sector edge (either
  // sign), and some anywhere in the 16-bit field.
  function automatic logic [15:0] rand_angle();
    int sel;
    int t;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      t = int'($urandom_range(0, 2 * ANG_PI)) - ANG_PI;
    end else if (sel < 9) begin
      t = ANGLE_EDGES[$urandom_range(0, 4)] + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) t = t - ANG_PI;
    end else begin
      t = int'($urandom_range(0, 65535));
    end
    return t[15:0];
  endfunction

  // Offers one pixel word after a random gap and returns at the falling
  // edge after it was taken, with valid still high.
  task automatic push_word(input logic [15:0] mag, input logic [15:0] ang,
                           input logic pad, input logic start);
    while ($urandom_range(0, 99) < src_idle) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.magnitude   <= mag;
    pix_ch.angle       <= ang;
    pix_ch.pad         <= pad;
    pix_ch.frame_start <= start;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // One register access: a setup phase, then an access phase held until
  // pready.
  task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stops offering words and waits until the block has nothing left to do.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Sends one frame. Most frames are well formed: a frame start, every
  // pixel, then the pads that flush the tail. The rest are cut short, carry
  // noise pads that may restart the counters, or end with too few or too
  // many pads. Large frames are always cut short.
  task automatic send_frame(input int w, input int h);
    int  npix;
    int  npads;
    int  i;
    int  roll;
    bit  tidy;
    tidy = ($urandom_range(0, 99) < 80);
    if (w * h > BIG_FRAME) npix = $urandom_range(w + 2, w + 60);
    else if (tidy) npix = w * h;
    else npix = $urandom_range(1, w * h);
    for (i = 0; i < npix; i++) begin
      if (!tidy && $urandom_range(0, 99) < 4)
        push_word(rand_mag(), rand_angle(), 1'b1, 1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 99) < 2)
        push_word(rand_mag(), rand_angle(), 1'b1, 1'b0);
      push_word(rand_mag(), rand_angle(), 1'b0, (i == 0) && ($urandom_range(0, 99) < 85));
    end
    if (npix == w * h) begin
      npads = w + 1;
      roll  = $urandom_range(0, 99);
      if (roll < 12) npads = npads + $urandom_range(1, 3);
      else if (roll < 20) npads = $urandom_range(0, w);
    end else begin
      npads = $urandom_range(0, 3);
    end
    for (i = 0; i < npads; i++) push_word(rand_mag(), rand_angle(), 1'b1, 1'b0);
    words_sent = words_sent + npix + npads;
  endtask

  // Writes a new frame size while the block is idle, reads it back, then
  // sends frames until the word budget is spent. A hold request, when
  // asked, starts the long result stall just as the frames begin.
  task automatic run_setting(input int wr, input int hr, input int budget, input bit hold);
    int w;
    int h;
    int first;
    settle();
    apb_xfer(1'b1, REG_WIDTH, 32'(wr));
    apb_xfer(1'b1, REG_HEIGHT, 32'(hr));
    apb_xfer(1'b0, REG_WIDTH, 32'd0);
    apb_xfer(1'b0, REG_HEIGHT, 32'd0);
    w     = clamp_dim(wr, DEF_MAX_WIDTH);
    h     = clamp_dim(hr, HEIGHT_CAP);
    first = words_sent;
    if (hold) hold_reqs++;
    do send_frame(w, h); while (words_sent - first < budget);
  endtask

  initial begin
    int phase;
    int k;
    int phase_first;
    int drain;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.magnitude   = '0;
    pix_ch.angle       = '0;
    pix_ch.pad         = 1'b0;
    pix_ch.frame_start = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (phase = 0; phase < 3; phase++) begin
      // Sender and receiver idle rates: one busy side, then the other,
      // then both running flat out.
      case (phase)
        0: begin
          src_idle = 15;
          snk_idle = 64;
        end
        1: begin
          src_idle = 64;
          snk_idle = 15;
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
        end
      endcase

      if (phase == 0) begin
        // Smallest frame. Only the center pixel is compared; it is
        // horizontal and its right neighbor is larger, so it is zeroed.
        // The other pixels sit on sector edges, fold negative angles and
        // carry the magnitude extremes.
        run_setting(3, 3, 0, 1'b0);
        push_word(16'd0, 16'(-ANG_PI), 1'b0, 1'b1);
        push_word(16'hFFFF, 16'(ANG_PI), 1'b0, 1'b0);
        push_word(16'd7, 16'd3217, 1'b0, 1'b0);
        push_word(16'd100, 16'd3218, 1'b0, 1'b0);
        push_word(16'd500, 16'd16085, 1'b0, 1'b0);
        push_word(16'd600, 16'd9652, 1'b0, 1'b0);
        push_word(16'd3, 16'd16086, 1'b0, 1'b0);
        push_word(16'd1, 16'd22519, 1'b0, 1'b0);
        push_word(16'd2, 16'd22520, 1'b0, 1'b0);
        // Four pads flush the tail; the fifth one is surplus and ignored.
        repeat (5) push_word(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        // A pad with a frame start only restarts the counters. Two frame
        // starts back to back land on column zero twice in a row. Out of
        // range angles are folded like any other. A pad inside a frame is
        // ignored.
        push_word(16'h5A5A, 16'h0000, 1'b1, 1'b1);
        push_word(16'hFFFF, 16'h8000, 1'b0, 1'b1);
        push_word(16'h0000, 16'h7FFF, 1'b0, 1'b1);
        push_word(16'h0001, 16'hFFFF, 1'b0, 1'b0);
        push_word(16'h0000, 16'h0000, 1'b1, 1'b0);
        words_sent = words_sent + 19;
      end

      // The frame left open above, and any frame cut short later, meet a
      // new size here, so a column counter past the new width wraps.
      phase_first = words_sent;
      for (k = 0; k < 3; k++)
        run_setting(FIXED_W[3*phase+k], FIXED_H[3*phase+k], SET_WORDS, k == 0);
      while (words_sent - phase_first < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0)
          run_setting($urandom_range(0, 2), $urandom_range(0, 2), SET_WORDS, 1'b0);
        else
          run_setting($urandom_range(3, 14), $urandom_range(3, 9), SET_WORDS, 1'b0);
      end
    end

    // Let every awaited result word arrive, then keep the clock running for the
    // drain margin so that any word that should not be there shows up.
    pix_ch.valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending != 0) $display("%0d awaited result words never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
